### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the RTL; compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property checked at every rising edge outside reset.
`define ASSERT_AT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Condition that must never hold outside reset.
`define ASSERT_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_AT(name, clk, rst_n, prop)
`define ASSERT_NEVER(name, clk, rst_n, cond)

`endif

`endif

### hw/rtl/vsac_pkg.sv
// ----------------------------------------------------------------------------
// vsac_pkg
// Types and constants shared by the velocity split and altitude check block.
// ----------------------------------------------------------------------------
package vsac_pkg;

  // Fixed widths of the datapath.
  localparam int unsigned RootBits   = 24;
  localparam int unsigned RadBits    = 2 * RootBits;
  localparam int unsigned ClimbBits  = 64;
  localparam int unsigned AltErrBits = 48;
  localparam int unsigned QueueDepth = 2;

  // One telemetry sample.
  typedef struct packed {
    logic        [31:0] sample_time;
    logic        [23:0] speed;
    logic signed [23:0] vertical_velocity;
    logic signed [31:0] altitude;
  } in_item_t;

  // One result.
  typedef struct packed {
    logic        [23:0] horizontal_velocity;
    logic signed [23:0] vertical_out;
    logic        [23:0] speed_error;
    logic signed [47:0] altitude_error;
  } out_item_t;

  // Work handed from the front to the root engine.
  typedef struct packed {
    logic        [RadBits-1:0]    radicand;
    logic signed [23:0]           vertical_out;
    logic        [23:0]           speed_error;
    logic signed [AltErrBits-1:0] altitude_error;
  } queue_entry_t;

endpackage

### hw/rtl/vsac_front.sv
// ----------------------------------------------------------------------------
// vsac_front
// Accepts samples, updates the climb integral and forms the root radicand.
// ----------------------------------------------------------------------------
module vsac_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  vsac_pkg::in_item_t    in_data_i,
  output logic                  push_valid_o,
  input  logic                  push_ready_i,
  output vsac_pkg::queue_entry_t push_data_o
);
  import vsac_pkg::*;

  typedef enum logic [1:0] {F_IDLE, F_MUL, F_ACC, F_PUSH} front_state_e;

  front_state_e               state_q;
  logic        [31:0]         prev_time_q;
  logic signed [32:0]         dt_q;
  logic        [23:0]         speed_q;
  logic signed [23:0]         vy_q;
  logic        [23:0]         vabs_q;
  logic        [23:0]         serr_q;
  logic signed [31:0]         alt_q;
  logic signed [56:0]         prod_q;
  logic        [RadBits-1:0]  ssq_q;
  logic        [RadBits-1:0]  vsq_q;
  logic        [RadBits-1:0]  hsq_q;
  logic signed [ClimbBits-1:0] climb_q;

  logic        [23:0]          vabs_d;
  logic        [23:0]          serr_d;
  logic signed [32:0]          dt_d;
  logic signed [ClimbBits:0]   sum_w;
  logic signed [ClimbBits-1:0] climb_d;
  logic        [RadBits-1:0]   hsq_d;
  logic signed [56:0]          err_w;
  logic signed [AltErrBits-1:0] err_sat;
  logic                        in_accept;

  assign in_ready_o = (state_q == F_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;

  // Magnitude of the vertical velocity and how far it exceeds the speed.
  always_comb begin
    vabs_d = in_data_i.vertical_velocity[23] ? 24'(-in_data_i.vertical_velocity)
                                             : 24'(in_data_i.vertical_velocity);
    serr_d = (vabs_d > in_data_i.speed) ? (vabs_d - in_data_i.speed) : '0;
    dt_d   = $signed({1'b0, in_data_i.sample_time}) - $signed({1'b0, prev_time_q});
  end

  // Saturating integral update and the horizontal square.
  always_comb begin
    sum_w = {climb_q[ClimbBits-1], climb_q} + (ClimbBits+1)'(prod_q);
    if (sum_w[ClimbBits] != sum_w[ClimbBits-1]) begin
      climb_d = sum_w[ClimbBits] ? {1'b1, {(ClimbBits-1){1'b0}}}
                                 : {1'b0, {(ClimbBits-1){1'b1}}};
    end else begin
      climb_d = sum_w[ClimbBits-1:0];
    end
    hsq_d = ssq_q - ((vsq_q < ssq_q) ? vsq_q : ssq_q);
  end

  // Floor of the integral in mm minus the altitude, saturated to the field.
  always_comb begin
    err_w = 57'($signed(climb_q[ClimbBits-1:8])) - 57'(alt_q);
    if (err_w[56:AltErrBits-1] != {(57-AltErrBits+1){err_w[56]}}) begin
      err_sat = err_w[56] ? {1'b1, {(AltErrBits-1){1'b0}}}
                          : {1'b0, {(AltErrBits-1){1'b1}}};
    end else begin
      err_sat = err_w[AltErrBits-1:0];
    end
  end

  assign push_valid_o                = (state_q == F_PUSH);
  assign push_data_o.radicand        = hsq_q;
  assign push_data_o.vertical_out    = vy_q;
  assign push_data_o.speed_error     = serr_q;
  assign push_data_o.altitude_error  = err_sat;

  // Sequencer and datapath registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= F_IDLE;
      prev_time_q <= '0;
      climb_q     <= '0;
    end else begin
      unique case (state_q)
        F_IDLE: begin
          if (in_accept) begin
            prev_time_q <= in_data_i.sample_time;
            dt_q        <= dt_d;
            speed_q     <= in_data_i.speed;
            vy_q        <= in_data_i.vertical_velocity;
            vabs_q      <= vabs_d;
            serr_q      <= serr_d;
            alt_q       <= in_data_i.altitude;
            state_q     <= F_MUL;
          end
        end
        F_MUL: begin
          prod_q  <= vy_q * dt_q;
          ssq_q   <= speed_q * speed_q;
          vsq_q   <= vabs_q * vabs_q;
          state_q <= F_ACC;
        end
        F_ACC: begin
          climb_q <= climb_d;
          hsq_q   <= hsq_d;
          state_q <= F_PUSH;
        end
        F_PUSH: begin
          if (push_ready_i) begin
            state_q <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

endmodule

### hw/rtl/vsac_queue.sv
// ----------------------------------------------------------------------------
// vsac_queue
// Short first-in first-out queue between the front and the root engine.
// ----------------------------------------------------------------------------
module vsac_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_valid_i,
  output logic                   push_ready_o,
  input  vsac_pkg::queue_entry_t push_data_i,
  output logic                   pop_valid_o,
  input  logic                   pop_ready_i,
  output vsac_pkg::queue_entry_t pop_data_o
);
  import vsac_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  queue_entry_t        entry_q [QueueDepth];
  logic [PtrW-1:0]     wr_ptr_q;
  logic [PtrW-1:0]     rd_ptr_q;
  logic [CntW-1:0]     count_q;
  logic                do_push;
  logic                do_pop;

  assign push_ready_o = (count_q != CntW'(QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = entry_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

### hw/rtl/vsac_back.sv
// ----------------------------------------------------------------------------
// vsac_back
// Digit-by-digit square root, one result bit per cycle, and the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vsac_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   pop_valid_i,
  output logic                   pop_ready_o,
  input  vsac_pkg::queue_entry_t pop_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output vsac_pkg::out_item_t    out_data_o
);
  import vsac_pkg::*;

  localparam int unsigned RemW = RootBits + 4;
  localparam int unsigned CntW = $clog2(RootBits);

  typedef enum logic [1:0] {B_IDLE, B_ROOT, B_DONE} back_state_e;

  back_state_e                  state_q;
  logic        [CntW-1:0]       cnt_q;
  logic        [RadBits-1:0]    rad_q;
  logic        [RemW-1:0]       rem_q;
  logic        [RootBits-1:0]   root_q;
  logic signed [23:0]           vert_q;
  logic        [23:0]           serr_q;
  logic signed [AltErrBits-1:0] alt_err_q;
  logic                         out_valid_q;
  out_item_t                    out_q;

  logic [RemW-1:0] rem_shift;
  logic [RemW-1:0] trial;
  logic            fits;
  logic            pop_accept;
  logic            out_free;
  logic            root_last;
  logic            load_out;

  assign pop_ready_o = (state_q == B_IDLE);
  assign pop_accept  = pop_valid_i && pop_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign root_last   = (state_q == B_ROOT) && (cnt_q == CntW'(RootBits - 1));
  assign load_out    = (state_q == B_DONE) && out_free;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // One root step: bring down two radicand bits and try the next digit.
  always_comb begin
    rem_shift = {rem_q[RemW-3:0], rad_q[RadBits-1 -: 2]};
    trial     = {{(RemW-RootBits-2){1'b0}}, root_q, 2'b01};
    fits      = (rem_shift >= trial);
  end

  // Root sequencer and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // A new result takes the register; otherwise an accepted one leaves it.
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        B_IDLE: begin
          if (pop_accept) begin
            rad_q     <= pop_data_i.radicand;
            rem_q     <= '0;
            root_q    <= '0;
            vert_q    <= pop_data_i.vertical_out;
            serr_q    <= pop_data_i.speed_error;
            alt_err_q <= pop_data_i.altitude_error;
            cnt_q     <= '0;
            state_q   <= B_ROOT;
          end
        end
        B_ROOT: begin
          rem_q  <= fits ? (rem_shift - trial) : rem_shift;
          root_q <= {root_q[RootBits-2:0], fits};
          rad_q  <= {rad_q[RadBits-3:0], 2'b00};
          if (root_last) begin
            state_q <= B_DONE;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        B_DONE: begin
          if (out_free) begin
            out_q.horizontal_velocity <= root_q;
            out_q.vertical_out        <= vert_q;
            out_q.speed_error         <= serr_q;
            out_q.altitude_error      <= alt_err_q;
            state_q                   <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  // A popped transaction always starts the root from its first digit.
  `ASSERT_AT(a_pop_starts_root, clk_i, rst_ni, pop_accept |=> (state_q == B_ROOT) && (cnt_q == '0))
  // The root ends after exactly the last digit.
  `ASSERT_AT(a_root_ends, clk_i, rst_ni, root_last |=> (state_q == B_DONE))
  // A finished root with a free output register becomes a valid result.
  `ASSERT_AT(a_done_delivers, clk_i, rst_ni, load_out |=> out_valid_q && (state_q == B_IDLE))
  // The digit counter never runs past the root width.
  `ASSERT_NEVER(a_cnt_range, clk_i, rst_ni, cnt_q > CntW'(RootBits - 1))

endmodule

### hw/rtl/velocity_split_altitude_check.sv
// ----------------------------------------------------------------------------
// velocity_split_altitude_check
// Splits speed into a horizontal part and checks integrated climb against altitude.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake              Payload
// in        input      in_valid_i/in_ready_o  vsac_pkg::in_item_t
// out       output     out_valid_o/out_ready_i vsac_pkg::out_item_t
//
// The front steps through capture, multiply, integrate and hand-off into a
// two-entry queue for each transaction. The root engine loads a transaction,
// forms the square root (one result bit per cycle) and fills the output
// register before it takes the next one, so the root engine sets the sustained
// rate. Reset clears the previous time, the climb integral and all control
// state. A stalled output holds the root engine while the front keeps filling
// the queue.
// ----------------------------------------------------------------------------
module velocity_split_altitude_check (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  vsac_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output vsac_pkg::out_item_t out_data_o
);
  import vsac_pkg::*;

  logic         push_valid;
  logic         push_ready;
  queue_entry_t push_data;
  logic         pop_valid;
  logic         pop_ready;
  queue_entry_t pop_data;

  // Sample intake, integral and radicand.
  vsac_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .push_data_o (push_data)
  );

  // Decoupling queue.
  vsac_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_data_i (push_data),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_data_o  (pop_data)
  );

  // Square root and result register.
  vsac_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pop_valid_i(pop_valid),
    .pop_ready_o(pop_ready),
    .pop_data_i (pop_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

### verif/velocity_split_altitude_check_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// velocity_split_altitude_check_tb
// Self-checking bench for the velocity split and altitude check block.
// A queue of telemetry samples feeds a valid/ready driver. Each accepted
// transaction runs through a local model of the horizontal split, the speed
// error and the saturating climb integral. The monitor compares every result
// transaction with the oldest prediction. Both channels stall in random bursts.
// ----------------------------------------------------------------------------
module velocity_split_altitude_check_tb;
  import vsac_pkg::*;

  localparam int     StallLimit = 2000;
  localparam int     DrainCycles = 64;
  localparam int     ReportLimit = 10;
  localparam longint ClimbMax = longint'(64'h7FFF_FFFF_FFFF_FFFF);
  localparam longint ClimbMin = longint'(64'h8000_0000_0000_0000);
  localparam longint AltErrMax = longint'(64'h0000_7FFF_FFFF_FFFF);
  localparam longint AltErrMin = longint'(64'hFFFF_8000_0000_0000);

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // Stimulus and prediction state.
  in_item_t    sample_backlog[$];
  out_item_t   pending_results[$];
  logic [31:0] last_time = '0;
  longint      climb_sum = 0;
  logic [31:0] stim_time = '0;
  int          fault_count = 0;
  int          idle_cycles = 0;
  int          in_gap = 0;
  int          out_gap = 0;
  bit          in_taken = 1'b0;
  bit          steady = 1'b0;

  velocity_split_altitude_check dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always #2 clk = ~clk;

  // Horizontal split, speed error and climb integral for one sample.
  function automatic out_item_t split_sample(in_item_t smp);
    longint      vy, alt, dt, step, sum, err;
    logic [63:0] vabs, ssq, vsq, hsq, root, trial, spd;
    int          b;
    out_item_t   res;
    vy   = longint'($signed(smp.vertical_velocity));
    alt  = longint'($signed(smp.altitude));
    spd  = 64'(smp.speed);
    vabs = (vy < 0) ? 64'(-vy) : 64'(vy);
    ssq  = spd * spd;
    vsq  = vabs * vabs;
    hsq  = ssq - ((vsq < ssq) ? vsq : ssq);
    // Floor square root, one result bit at a time from the top.
    root = '0;
    for (b = 23; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= hsq) root = trial;
    end
    // Signed elapsed time; the integral saturates instead of wrapping.
    dt = longint'({32'd0, smp.sample_time}) - longint'({32'd0, last_time});
    last_time = smp.sample_time;
    step = vy * dt;
    sum = climb_sum + step;
    if (step > 0 && sum < climb_sum) begin
      sum = ClimbMax;
    end else if (step < 0 && sum > climb_sum) begin
      sum = ClimbMin;
    end
    climb_sum = sum;
    // Arithmetic shift gives the floor of the Q.8 to mm conversion.
    err = (climb_sum >>> 8) - alt;
    if (err > AltErrMax) begin
      err = AltErrMax;
    end else if (err < AltErrMin) begin
      err = AltErrMin;
    end
    res.horizontal_velocity = root[23:0];
    res.vertical_out        = smp.vertical_velocity;
    res.speed_error         = (vabs > spd) ? 24'(vabs - spd) : 24'd0;
    res.altitude_error      = err[47:0];
    return res;
  endfunction

  function automatic bit winding_down();
    return sample_backlog.size() < 30;
  endfunction

  function automatic logic [63:0] low_mask(int w);
    return (64'd1 << w) - 64'd1;
  endfunction

  task automatic add_sample(input logic [31:0] t, input logic [23:0] s,
                            input logic [23:0] v, input logic [31:0] a);
    in_item_t smp;
    smp.sample_time       = t;
    smp.speed             = s;
    smp.vertical_velocity = v;
    smp.altitude          = a;
    sample_backlog.push_back(smp);
  endtask

  // Ordinary telemetry: time mostly moves forward, magnitudes of mixed size.
  task automatic add_random_sample();
    logic [23:0] spd, mag;
    logic [31:0] alt;
    case ($urandom_range(0, 19))
      0:       stim_time = $urandom;
      1:       stim_time = stim_time - $urandom_range(1, 5000);
      default: stim_time = stim_time + $urandom_range(0, 2000);
    endcase
    spd = 24'($urandom & low_mask($urandom_range(0, 24)));
    mag = 24'($urandom & low_mask($urandom_range(0, 24)));
    if ($urandom_range(0, 3) == 0) mag = spd + 24'($urandom_range(0, 4)) - 24'd2;
    alt = 32'($urandom & low_mask($urandom_range(0, 32)));
    add_sample(stim_time, spd, $urandom_range(0, 1) ? -mag : mag,
               $urandom_range(0, 1) ? -alt : alt);
  endtask

  // Time swings between its extremes with vertical velocity at full scale,
  // so each transaction moves the integral by about 2^55 in one direction.
  task automatic add_swing(input int count, input bit upward);
    logic [23:0] vy;
    int          i;
    for (i = 0; i < count; i++) begin
      stim_time = i[0] ? 32'hFFFF_FFFF : 32'h0;
      if (i[0] == upward) begin
        vy = 24'h7F_FFFF - 24'($urandom_range(0, 255));
      end else begin
        vy = 24'h80_0000 + 24'($urandom_range(0, 255));
      end
      add_sample(stim_time, 24'($urandom), vy, $urandom);
    end
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (pending_results.size() == 0) begin
      fault_count++;
      if (fault_count <= ReportLimit)
        $display("unexpected result transaction: h=%h v=%h se=%h ae=%h",
                 got.horizontal_velocity, got.vertical_out, got.speed_error,
                 got.altitude_error);
    end else begin
      want = pending_results.pop_front();
      if (got.horizontal_velocity !== want.horizontal_velocity ||
          got.vertical_out !== want.vertical_out ||
          got.speed_error !== want.speed_error ||
          got.altitude_error !== want.altitude_error) begin
        fault_count++;
        if (fault_count <= ReportLimit)
          $display("mismatch: expected h=%h v=%h se=%h ae=%h, got h=%h v=%h se=%h ae=%h",
                   want.horizontal_velocity, want.vertical_out, want.speed_error,
                   want.altitude_error, got.horizontal_velocity, got.vertical_out,
                   got.speed_error, got.altitude_error);
      end
    end
  endtask

  // Sample both handshakes, predict, check, and watch for a hang.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken = 1'b0;
      idle_cycles = 0;
    end else begin
      in_taken = in_valid && in_ready;
      if (in_taken) pending_results.push_back(split_sample(in_data));
      if (out_valid && out_ready) check_result(out_data);
      if ($urandom_range(0, 299) == 0) steady = !steady;
      if (in_taken || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= StallLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Input driver: holds a pending transaction, otherwise idles or sends.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (!steady && !winding_down() && $urandom_range(0, 5) == 0) begin
        in_gap = $urandom_range(0, 8);
        in_valid <= 1'b0;
      end else if (sample_backlog.size() != 0) begin
        in_data <= sample_backlog.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output back-pressure in random bursts.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_ready <= 1'b0;
    end else if (!steady && !winding_down() && $urandom_range(0, 5) == 0) begin
      out_gap = $urandom_range(0, 8);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin
    // First sample measures its elapsed time from zero.
    add_sample(32'd5000, 24'h00_0000, 24'h00_0100, 32'h0);
    add_sample(32'd6000, 24'hFF_FFFF, 24'h00_0000, 32'h7FFF_FFFF);
    add_sample(32'd6000, 24'hFF_FFFF, 24'h7F_FFFF, 32'h8000_0000);
    add_sample(32'd7000, 24'h00_0000, 24'h80_0000, 32'h0);
    add_sample(32'd7001, 24'h00_0000, 24'h7F_FFFF, 32'hFFFF_FFFF);
    // Vertical magnitude equal to speed, both signs, then one LSB above it.
    add_sample(32'd7002, 24'h12_3456, 24'h12_3456, 32'd1234);
    add_sample(32'd7003, 24'h12_3456, -24'h12_3456, 32'h0);
    add_sample(32'd7004, 24'h00_0100, -24'h00_0101, 32'h0);
    add_sample(32'd7005, 24'h00_0500, 24'h00_0300, 32'h0);
    add_sample(32'd7006, 24'h00_0001, 24'h00_0000, 32'h0);
    // Time going backwards lowers the integral.
    add_sample(32'd3000, 24'h00_ABCD, 24'h00_1000, 32'd100);
    // Large swings push the altitude error to its upper bound ...
    add_sample(32'hFFFF_FFFF, 24'h80_0000, 24'h7F_FFFF, 32'h8000_0000);
    add_sample(32'h0, 24'hFF_FFFF, 24'h80_0000, 32'h8000_0000);
    // ... and then to its lower bound.
    add_sample(32'hFFFF_FFFF, 24'h7F_FFFF, 24'h80_0000, 32'h7FFF_FFFF);
    add_sample(32'h0, 24'h00_1234, 24'h7F_FFFF, 32'h7FFF_FFFF);
    add_sample(32'hFFFF_FFFF, 24'h00_0000, 24'h80_0000, 32'h0);
    add_sample(32'h0, 24'hFF_FFFF, 24'h7F_FFFF, 32'h8000_0000);
    add_sample(32'hFFFF_FFFF, 24'h55_5555, 24'h80_0000, 32'hAAAA_AAAA);
    add_sample(32'd100, 24'hFF_FFFF, 24'h00_0000, 32'h0);
    add_sample(32'd200, 24'h00_0000, -24'h00_0001, 32'h1);
    stim_time = 32'd200;

    // Random part: the integral is driven into both of its saturation bounds.
    repeat (10) add_random_sample();
    add_swing(270, 1'b0);
    repeat (10) add_random_sample();
    add_swing(530, 1'b1);
    repeat (30) add_random_sample();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (sample_backlog.size() != 0 || in_valid || pending_results.size() != 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (fault_count == 0 && pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
